@@ sv/identical_k_of_n_reliability_macros.svh @@
// Assertion macros shared by the sequencer and the datapath.
`ifndef IDENTICAL_K_OF_N_RELIABILITY_MACROS_SVH
`define IDENTICAL_K_OF_N_RELIABILITY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IKN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ikn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IKN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ikn assertion failed");

`endif

@@ sv/ikn_pkg.sv @@
`timescale 1ns / 1ps

package ikn_pkg;

	localparam int CNT_W  = 6;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int PC_W   = 4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_COUNT     = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_FAILURE   = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] threshold;
		logic             failure_mode;
	} cfg_t;

	// Datapath micro-operations.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_TERM_INIT,
		DP_LOAD_FACTOR,
		DP_MUL,
		DP_ROUND,
		DP_LOAD_COEF,
		DP_ACCUM,
		DP_OUTPUT,
		DP_BUILD_INIT,
		DP_ROW_INIT,
		DP_BUILD_READ,
		DP_BUILD_WRITE,
		DP_ROW_NEXT
	} dp_op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_W_GT_N,
		C_J_EQ_N,
		C_CHUNK_NZ,
		C_J_NE_1
	} cond_t;

	typedef struct packed {
		dp_op_t          op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
		logic            wait_out;
	} ucode_t;

	typedef struct packed {
		logic   step_en;
		logic   start_eval;
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic w_gt_n;
		logic j_eq_n;
		logic chunk_nz;
		logic j_ne_1;
	} dp_status_t;

	// Program entry points and jump targets.
	localparam logic [PC_W-1:0] PC_EV_TERM  = 4'd0;
	localparam logic [PC_W-1:0] PC_EV_FACT  = 4'd1;
	localparam logic [PC_W-1:0] PC_EV_MUL   = 4'd2;
	localparam logic [PC_W-1:0] PC_EV_RND   = 4'd3;
	localparam logic [PC_W-1:0] PC_EV_COEF  = 4'd4;
	localparam logic [PC_W-1:0] PC_EV_CMUL  = 4'd5;
	localparam logic [PC_W-1:0] PC_EV_ACC   = 4'd6;
	localparam logic [PC_W-1:0] PC_EV_FIN   = 4'd7;
	localparam logic [PC_W-1:0] PC_BD_INIT  = 4'd8;
	localparam logic [PC_W-1:0] PC_BD_ROW   = 4'd9;
	localparam logic [PC_W-1:0] PC_BD_READ  = 4'd10;
	localparam logic [PC_W-1:0] PC_BD_WRITE = 4'd11;
	localparam logic [PC_W-1:0] PC_BD_NEXT  = 4'd12;
	localparam logic [PC_W-1:0] PC_BD_END   = 4'd13;

	// Control store. The evaluation program walks every term of the sum,
	// the build program fills one Pascal row into the coefficient memory.
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t cw;
		cw = '{op: DP_NOP, cond: C_NEVER, target: PC_EV_TERM, last: 1'b1, wait_out: 1'b0};
		case (pc)
			PC_EV_TERM:  cw = '{op: DP_TERM_INIT,   cond: C_W_GT_N,   target: PC_EV_FIN,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_FACT:  cw = '{op: DP_LOAD_FACTOR, cond: C_J_EQ_N,   target: PC_EV_COEF,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_MUL:   cw = '{op: DP_MUL,         cond: C_CHUNK_NZ, target: PC_EV_MUL,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_RND:   cw = '{op: DP_ROUND,       cond: C_ALWAYS,   target: PC_EV_FACT,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_COEF:  cw = '{op: DP_LOAD_COEF,   cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_CMUL:  cw = '{op: DP_MUL,         cond: C_CHUNK_NZ, target: PC_EV_CMUL,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_ACC:   cw = '{op: DP_ACCUM,       cond: C_ALWAYS,   target: PC_EV_TERM,
				last: 1'b0, wait_out: 1'b0};
			PC_EV_FIN:   cw = '{op: DP_OUTPUT,      cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b1, wait_out: 1'b1};
			PC_BD_INIT:  cw = '{op: DP_BUILD_INIT,  cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b0, wait_out: 1'b0};
			PC_BD_ROW:   cw = '{op: DP_ROW_INIT,    cond: C_W_GT_N,   target: PC_BD_END,
				last: 1'b0, wait_out: 1'b0};
			PC_BD_READ:  cw = '{op: DP_BUILD_READ,  cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b0, wait_out: 1'b0};
			PC_BD_WRITE: cw = '{op: DP_BUILD_WRITE, cond: C_J_NE_1,   target: PC_BD_READ,
				last: 1'b0, wait_out: 1'b0};
			PC_BD_NEXT:  cw = '{op: DP_ROW_NEXT,    cond: C_ALWAYS,   target: PC_BD_ROW,
				last: 1'b0, wait_out: 1'b0};
			PC_BD_END:   cw = '{op: DP_NOP,         cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b1, wait_out: 1'b0};
			default:     cw = '{op: DP_NOP,         cond: C_NEVER,    target: PC_EV_TERM,
				last: 1'b1, wait_out: 1'b0};
		endcase
		return cw;
	endfunction

endpackage

@@ sv/ikn_ram.sv @@
`timescale 1ns / 1ps

module ikn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ikn_sequencer.sv @@
`timescale 1ns / 1ps
`include "identical_k_of_n_reliability_macros.svh"

module ikn_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                count_wr,
	input  logic                out_blocked,
	input  ikn_pkg::dp_status_t status,
	output ikn_pkg::dp_ctrl_t   ctrl,
	output logic                busy
);

	logic [ikn_pkg::PC_W-1:0] pc_q;
	logic                     running_q;
	logic                     pend_q;
	ikn_pkg::ucode_t          cw;
	logic                     cond_hit;
	logic                     step_en;

	always_comb begin
		cw = ikn_pkg::ucode(pc_q);
		case (cw.cond)
			ikn_pkg::C_NEVER:    cond_hit = 1'b0;
			ikn_pkg::C_ALWAYS:   cond_hit = 1'b1;
			ikn_pkg::C_W_GT_N:   cond_hit = status.w_gt_n;
			ikn_pkg::C_J_EQ_N:   cond_hit = status.j_eq_n;
			ikn_pkg::C_CHUNK_NZ: cond_hit = status.chunk_nz;
			ikn_pkg::C_J_NE_1:   cond_hit = status.j_ne_1;
			default:             cond_hit = 1'b0;
		endcase
	end

	// The output step holds while the previous result still waits.
	assign step_en = running_q && !(cw.wait_out && out_blocked);

	assign ctrl.step_en    = step_en;
	assign ctrl.start_eval = accept;
	assign ctrl.op         = cw.op;
	assign busy            = running_q || pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= ikn_pkg::PC_EV_TERM;
			running_q <= 1'b0;
			pend_q    <= 1'b1;
		end else begin
			if (!running_q) begin
				if (pend_q) begin
					running_q <= 1'b1;
					pc_q      <= ikn_pkg::PC_BD_INIT;
					pend_q    <= 1'b0;
				end else if (accept) begin
					running_q <= 1'b1;
					pc_q      <= ikn_pkg::PC_EV_TERM;
				end
			end else if (step_en) begin
				if (cond_hit) begin
					pc_q <= cw.target;
				end else if (cw.last) begin
					running_q <= 1'b0;
				end else begin
					pc_q <= pc_q + ikn_pkg::PC_W'(1);
				end
			end
			if (count_wr) begin
				pend_q <= 1'b1;
			end
		end
	end

	`IKN_ASSERT_NEXT(a_eval_entry, clk, arst_n, accept, running_q && pc_q == ikn_pkg::PC_EV_TERM)
	`IKN_ASSERT_NEXT(a_build_entry, clk, arst_n, !running_q && pend_q,
		running_q && pc_q == ikn_pkg::PC_BD_INIT)

endmodule

@@ sv/ikn_datapath.sv @@
`timescale 1ns / 1ps
`include "identical_k_of_n_reliability_macros.svh"

module ikn_datapath #(
	parameter int MAX_COMPONENTS = 32,
	parameter int FRAC_BITS      = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ikn_pkg::dp_ctrl_t   ctrl,
	input  ikn_pkg::cfg_t       cfg,
	input  logic [31:0]         component_reliability,
	input  logic                result_stall,
	output ikn_pkg::dp_status_t status,
	output logic                out_blocked,
	output logic                result_valid,
	output logic [31:0]         system_reliability
);

	localparam int W   = FRAC_BITS + 1;
	localparam int H   = (W + 1) / 2;
	localparam int CW  = MAX_COMPONENTS;
	localparam int MW  = (CW > W) ? CW : W;
	localparam int NC  = (MW + H - 1) / H;
	localparam int BW  = NC * H;
	localparam int PW  = W + BW;
	localparam int CHW = (NC > 1) ? $clog2(NC) : 1;
	localparam int AW  = $clog2(MAX_COMPONENTS + 1);
	localparam int NWR = $clog2(MAX_COMPONENTS + 2);
	localparam int NW  = (NWR > ikn_pkg::CNT_W) ? NWR : ikn_pkg::CNT_W;
	localparam int XW  = (W > 32) ? W : 32;

	localparam logic [W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0] HALF = ONE >> 1;

	logic [W-1:0]   f1_q, f2_q, p_q, acc_q;
	logic [NW-1:0]  w_q, j_q;
	logic [BW-1:0]  b_q;
	logic [PW-1:0]  prod_q;
	logic [CHW-1:0] chunk_q;
	logic [CW-1:0]  carry_q;
	logic [31:0]    out_q;
	logic           out_valid_q;

	logic [NW-1:0]  count_x, n_eff, jm1;
	logic [XW-1:0]  r_x, res_x;
	logic [W-1:0]   r_sat, u_val, term, res;
	logic [W+H-1:0] mul_full;
	logic [PW-1:0]  prod_next, rnd_sum;
	logic [W:0]     acc_sum;
	logic           run;

	logic           ram_wen, ram_ren;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [CW-1:0]  ram_wdata, ram_rdata;

	assign count_x = NW'(cfg.count);
	assign n_eff   = (count_x > NW'(MAX_COMPONENTS)) ? NW'(MAX_COMPONENTS) : count_x;
	assign jm1     = j_q - NW'(1);

	assign r_x   = XW'(component_reliability);
	assign r_sat = (r_x > XW'(ONE)) ? ONE : W'(r_x);
	assign u_val = ONE - r_sat;

	// Partial product of the multiplicand with the top chunk of the operand.
	assign mul_full  = (W+H)'(p_q) * (W+H)'(b_q[BW-1 -: H]);
	assign prod_next = {prod_q[PW-H-1:0], {H{1'b0}}} + PW'(mul_full);
	assign rnd_sum   = prod_q + PW'(HALF);
	assign term      = (prod_q > PW'(ONE)) ? ONE : W'(prod_q);
	assign acc_sum   = (W+1)'(acc_q) + (W+1)'(term);
	assign res       = cfg.failure_mode ? (ONE - acc_q) : acc_q;
	assign res_x     = XW'(res);

	assign status.w_gt_n   = w_q > n_eff;
	assign status.j_eq_n   = j_q == n_eff;
	assign status.chunk_nz = chunk_q != '0;
	assign status.j_ne_1   = j_q != NW'(1);

	assign run = ctrl.step_en;

	always_comb begin
		ram_wen   = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_ren   = 1'b0;
		ram_raddr = '0;
		if (run) begin
			case (ctrl.op)
				ikn_pkg::DP_TERM_INIT: begin
					ram_ren   = !status.w_gt_n;
					ram_raddr = w_q[AW-1:0];
				end
				ikn_pkg::DP_BUILD_INIT: begin
					ram_wen   = 1'b1;
					ram_wdata = CW'(1);
				end
				ikn_pkg::DP_BUILD_READ: begin
					ram_ren   = 1'b1;
					ram_raddr = jm1[AW-1:0];
				end
				ikn_pkg::DP_BUILD_WRITE: begin
					ram_wen   = 1'b1;
					ram_waddr = j_q[AW-1:0];
					ram_wdata = carry_q + ram_rdata;
				end
				default: begin
				end
			endcase
		end
	end

	ikn_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_COMPONENTS + 1)
	) u_coef_ram (
		.clk  (clk),
		.wen  (ram_wen),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.ren  (ram_ren),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.start_eval) begin
			f1_q  <= cfg.failure_mode ? u_val : r_sat;
			f2_q  <= cfg.failure_mode ? r_sat : u_val;
			acc_q <= '0;
			w_q   <= NW'(cfg.threshold);
		end else if (run) begin
			case (ctrl.op)
				ikn_pkg::DP_TERM_INIT: begin
					p_q <= ONE;
					j_q <= '0;
				end
				ikn_pkg::DP_LOAD_FACTOR: begin
					b_q     <= BW'((j_q < w_q) ? f1_q : f2_q);
					prod_q  <= '0;
					chunk_q <= CHW'(NC - 1);
				end
				ikn_pkg::DP_MUL: begin
					prod_q  <= prod_next;
					b_q     <= b_q << H;
					chunk_q <= chunk_q - CHW'(1);
				end
				ikn_pkg::DP_ROUND: begin
					p_q <= rnd_sum[FRAC_BITS +: W];
					j_q <= j_q + NW'(1);
				end
				ikn_pkg::DP_LOAD_COEF: begin
					b_q     <= BW'(ram_rdata);
					prod_q  <= '0;
					chunk_q <= CHW'(NC - 1);
				end
				ikn_pkg::DP_ACCUM: begin
					acc_q <= (acc_sum > (W+1)'(ONE)) ? ONE : acc_sum[W-1:0];
					w_q   <= w_q + NW'(1);
				end
				ikn_pkg::DP_OUTPUT: begin
					out_q <= res_x[31:0];
				end
				ikn_pkg::DP_BUILD_INIT: begin
					w_q <= NW'(1);
				end
				ikn_pkg::DP_ROW_INIT: begin
					j_q     <= w_q;
					carry_q <= '0;
				end
				ikn_pkg::DP_BUILD_WRITE: begin
					carry_q <= ram_rdata;
					j_q     <= jm1;
				end
				ikn_pkg::DP_ROW_NEXT: begin
					w_q <= w_q + NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (run && ctrl.op == ikn_pkg::DP_OUTPUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_blocked        = out_valid_q && result_stall;
	assign result_valid       = out_valid_q;
	assign system_reliability = out_q;

	`IKN_ASSERT_IMPL(a_no_overwrite, clk, arst_n, run && ctrl.op == ikn_pkg::DP_OUTPUT,
		!(out_valid_q && result_stall))
	`IKN_ASSERT_NEXT(a_acc_bound, clk, arst_n, run && ctrl.op == ikn_pkg::DP_ACCUM, acc_q <= ONE)
	`IKN_ASSERT_NEXT(a_pow_bound, clk, arst_n, run && ctrl.op == ikn_pkg::DP_ROUND, p_q <= ONE)

endmodule

@@ sv/identical_k_of_n_reliability.sv @@
`timescale 1ns / 1ps
// K-of-N reliability of a system of identical components.
// Sample channel: component_reliability (Q1.31, values above 1.0 read as 1.0)
// moves on a transfer when sample_valid is high and sample_stall is low.
// Result channel: system_reliability (Q1.31, clamped to [0,1]) moves on a
// transfer when result_valid is high and result_stall is low; one result per sample.
// The APB port sets n (offset 0), k (offset 4) and failure mode (offset 8).
// A microcoded sequencer drives one shared multiplier, a chunk of the operand
// per cycle; the operand is split into NC chunks, 2 at the default widths.
// Most of the work for a sample is in the repeated power products.
// Samples are handled one at a time; sample_stall is high while one is at work.
// After reset, and after each write of n, the sequencer rebuilds the Pascal row
// in the coefficient memory, and no sample is taken during the rebuild.
// Configuration writes are taken at any time.
// A finished result sits in the output register; while result_stall holds
// it, the next sample may be taken and runs until its own result is ready.

module identical_k_of_n_reliability #(
	parameter int MAX_COMPONENTS = 32,
	parameter int FRAC_BITS      = 31
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic [31:0]                  component_reliability,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [31:0]                  system_reliability,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ikn_pkg::ADDR_W-1:0]   paddr,
	input  logic [ikn_pkg::DATA_W-1:0]   pwdata,
	output logic [ikn_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	ikn_pkg::cfg_t       cfg_q;
	ikn_pkg::dp_ctrl_t   ctrl;
	ikn_pkg::dp_status_t status;
	logic                cfg_wr;
	logic                count_wr;
	logic                accept;
	logic                busy;
	logic                out_blocked;
	logic [1:0]          reg_idx;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[3:2];
	assign cfg_wr   = psel && penable && pwrite;
	assign count_wr = cfg_wr && reg_idx == ikn_pkg::REG_COUNT;

	// Configuration registers; a write to an unknown offset is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count        <= ikn_pkg::CNT_W'(2);
			cfg_q.threshold    <= ikn_pkg::CNT_W'(1);
			cfg_q.failure_mode <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				ikn_pkg::REG_COUNT:     cfg_q.count        <= pwdata[ikn_pkg::CNT_W-1:0];
				ikn_pkg::REG_THRESHOLD: cfg_q.threshold    <= pwdata[ikn_pkg::CNT_W-1:0];
				ikn_pkg::REG_FAILURE:   cfg_q.failure_mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ikn_pkg::REG_COUNT:     prdata = ikn_pkg::DATA_W'(cfg_q.count);
			ikn_pkg::REG_THRESHOLD: prdata = ikn_pkg::DATA_W'(cfg_q.threshold);
			ikn_pkg::REG_FAILURE:   prdata = ikn_pkg::DATA_W'(cfg_q.failure_mode);
			default:                prdata = '0;
		endcase
	end

	// A sample is taken only while the sequencer is idle and no rebuild waits.
	assign sample_stall = busy;
	assign accept       = sample_valid && !busy;

	ikn_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.count_wr   (count_wr),
		.out_blocked(out_blocked),
		.status     (status),
		.ctrl       (ctrl),
		.busy       (busy)
	);

	ikn_datapath #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctrl                 (ctrl),
		.cfg                  (cfg_q),
		.component_reliability(component_reliability),
		.result_stall         (result_stall),
		.status               (status),
		.out_blocked          (out_blocked),
		.result_valid         (result_valid),
		.system_reliability   (system_reliability)
	);

endmodule
